### src/dau_pkg.sv
// ----------------------------------------------------------------------------
// dau_pkg: types and constants of the dihedral angle unit
// Item layouts, internal widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package dau_pkg;

    localparam int COORD_W = 20;            // Q10.10 coordinate
    localparam int B_W     = COORD_W + 1;   // bond vector component
    localparam int N_W     = 2 * B_W + 1;   // normal vector component
    localparam int LO_W    = 21;            // low half of a split operand
    localparam int LEN2_W  = 43;            // |b2|^2
    localparam int X_W     = 88;            // n1 . n2
    localparam int S_W     = 64;            // b1 . n2
    localparam int R_W     = 64;            // square root working width
    localparam int LENF_W  = 31;            // |b2| with ten extra fraction bits
    localparam int Y_W     = 96;            // -|b2| * (b1 . n2)
    localparam int U_W     = 128;           // normalizer width
    localparam int CV_W    = 30;            // CORDIC operand magnitude
    localparam int CX_W    = 34;            // CORDIC x/y register
    localparam int Z_W     = 25;            // angle accumulator, degrees Q16
    localparam int MAG_W   = 24;            // unsigned angle, degrees Q16
    localparam int CD_W    = 16;            // hundredths of a degree
    localparam int ATAN_W  = 22;

    localparam logic [MAG_W-1:0] DEG90_Q16  = MAG_W'(90 * 65536);
    localparam logic [MAG_W-1:0] DEG180_Q16 = MAG_W'(180 * 65536);
    localparam logic signed [CD_W-1:0] CD_90  = 16'sd9000;
    localparam logic signed [CD_W-1:0] CD_180 = 16'sd18000;

    typedef struct packed {
        logic signed [COORD_W-1:0] atom1_x;
        logic signed [COORD_W-1:0] atom1_y;
        logic signed [COORD_W-1:0] atom1_z;
        logic signed [COORD_W-1:0] atom2_x;
        logic signed [COORD_W-1:0] atom2_y;
        logic signed [COORD_W-1:0] atom2_z;
        logic signed [COORD_W-1:0] atom3_x;
        logic signed [COORD_W-1:0] atom3_y;
        logic signed [COORD_W-1:0] atom3_z;
        logic signed [COORD_W-1:0] atom4_x;
        logic signed [COORD_W-1:0] atom4_y;
        logic signed [COORD_W-1:0] atom4_z;
    } dau_in_t;

    typedef struct packed {
        logic signed [CD_W-1:0] torsion_angle;
        logic                   within_ninety;
    } dau_out_t;

    // atan(2^-i) in degrees, Q16, rounded to nearest
    function automatic logic [ATAN_W-1:0] atan_q16(input int unsigned idx);
        logic [ATAN_W-1:0] a;
        case (idx)
            0:       a = 22'd2949120;
            1:       a = 22'd1740967;
            2:       a = 22'd919879;
            3:       a = 22'd466945;
            4:       a = 22'd234379;
            5:       a = 22'd117304;
            6:       a = 22'd58666;
            7:       a = 22'd29335;
            8:       a = 22'd14668;
            9:       a = 22'd7334;
            10:      a = 22'd3667;
            11:      a = 22'd1833;
            12:      a = 22'd917;
            13:      a = 22'd458;
            14:      a = 22'd229;
            15:      a = 22'd115;
            16:      a = 22'd57;
            17:      a = 22'd29;
            18:      a = 22'd14;
            19:      a = 22'd7;
            20:      a = 22'd4;
            21:      a = 22'd2;
            22:      a = 22'd1;
            default: a = 22'd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

### src/dihedral_angle_unit.sv
// ----------------------------------------------------------------------------
// dihedral_angle_unit: torsion angle of four atoms
// Bond vectors, cross and dot products, |b2| by a pipelined square root,
// normalization and a pipelined vectoring CORDIC; one item per clock unless the output stalls.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | in_data  (dau_in_t, 12 coordinates)
//  out     | output    | out_valid / out_ready| out_data (dau_out_t, angle + flag)
//
//  The pipeline has 4 vector stages, 31 square root steps, 3 multiply stages,
//  7 normalize steps, the CORDIC steps and 2 output stages. One item enters per
//  cycle while the output is not stalled.
//  Reset clears only the valid bits; data registers are not reset.
//  A stalled output item freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module dihedral_angle_unit
    import dau_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire dau_in_t  in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output dau_out_t      out_data
);

    localparam int SQRT_STAGES = 31;
    localparam int NORM_STAGES = 7;
    localparam int DEPTH       = 4 + SQRT_STAGES + 3 + NORM_STAGES + CORDIC_STAGES + 2;
    localparam int NORM_LAST   = 4 + SQRT_STAGES + 3 + NORM_STAGES - 1;

    logic [DEPTH-1:0] valid_reg;
    logic             en;

    assign en        = !valid_reg[DEPTH-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = valid_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[DEPTH-2:0], in_valid};
        end
    end

    function automatic logic signed [N_W-1:0] cross_term(
        input logic signed [B_W-1:0] a,
        input logic signed [B_W-1:0] c,
        input logic signed [B_W-1:0] e,
        input logic signed [B_W-1:0] g
    );
        logic signed [2*B_W-1:0] p;
        logic signed [2*B_W-1:0] q;
        p = a * c;
        q = e * g;
        return N_W'(p) - N_W'(q);
    endfunction

    // ---------------- stage 1: bond vectors
    logic signed [COORD_W-1:0] atom [4][3];
    logic signed [B_W-1:0] b1_next [3], b2_next [3], b3_next [3];
    logic signed [B_W-1:0] b1_reg [3], b2_reg [3], b3_reg [3];

    assign atom[0][0] = in_data.atom1_x;
    assign atom[0][1] = in_data.atom1_y;
    assign atom[0][2] = in_data.atom1_z;
    assign atom[1][0] = in_data.atom2_x;
    assign atom[1][1] = in_data.atom2_y;
    assign atom[1][2] = in_data.atom2_z;
    assign atom[2][0] = in_data.atom3_x;
    assign atom[2][1] = in_data.atom3_y;
    assign atom[2][2] = in_data.atom3_z;
    assign atom[3][0] = in_data.atom4_x;
    assign atom[3][1] = in_data.atom4_y;
    assign atom[3][2] = in_data.atom4_z;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            b1_next[j] = B_W'(atom[1][j]) - B_W'(atom[0][j]);
            b2_next[j] = B_W'(atom[2][j]) - B_W'(atom[1][j]);
            b3_next[j] = B_W'(atom[3][j]) - B_W'(atom[2][j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_reg <= b1_next;
            b2_reg <= b2_next;
            b3_reg <= b3_next;
        end
    end

    // ---------------- stage 2: normals and |b2|^2
    logic signed [N_W-1:0]    n1_next [3], n2_next [3], n1_reg [3], n2_reg [3];
    logic signed [B_W-1:0]    b1c_reg [3];
    logic signed [2*B_W-1:0]  sq [3];
    logic [LEN2_W-1:0]        len2_next, len2_s2_reg;

    always_comb
    begin
        n1_next[0] = cross_term(b1_reg[1], b2_reg[2], b1_reg[2], b2_reg[1]);
        n1_next[1] = cross_term(b1_reg[2], b2_reg[0], b1_reg[0], b2_reg[2]);
        n1_next[2] = cross_term(b1_reg[0], b2_reg[1], b1_reg[1], b2_reg[0]);
        n2_next[0] = cross_term(b2_reg[1], b3_reg[2], b2_reg[2], b3_reg[1]);
        n2_next[1] = cross_term(b2_reg[2], b3_reg[0], b2_reg[0], b3_reg[2]);
        n2_next[2] = cross_term(b2_reg[0], b3_reg[1], b2_reg[1], b3_reg[0]);
        for (int j = 0; j < 3; j++)
        begin
            sq[j] = b2_reg[j] * b2_reg[j];
        end
        len2_next = LEN2_W'($unsigned(sq[0])) + LEN2_W'($unsigned(sq[1]))
                  + LEN2_W'($unsigned(sq[2]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg      <= n1_next;
            n2_reg      <= n2_next;
            b1c_reg     <= b1_reg;
            len2_s2_reg <= len2_next;
        end
    end

    // ---------------- stage 3: partial products of the dot products
    logic signed [2*(N_W-LO_W)-1:0] px_hh_next [3], px_hh_reg [3];
    logic signed [2*(N_W-LO_W)-1:0] px_hl_next [3], px_hl_reg [3];
    logic signed [2*(N_W-LO_W)-1:0] px_lh_next [3], px_lh_reg [3];
    logic [2*LO_W-1:0]              px_ll_next [3], px_ll_reg [3];
    logic signed [B_W+N_W-LO_W-1:0] ps_h_next [3], ps_h_reg [3];
    logic signed [B_W+N_W-LO_W-1:0] ps_l_next [3], ps_l_reg [3];
    logic [LEN2_W-1:0]              len2_s3_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            px_hh_next[j] = $signed(n1_reg[j][N_W-1:LO_W]) * $signed(n2_reg[j][N_W-1:LO_W]);
            px_hl_next[j] = $signed(n1_reg[j][N_W-1:LO_W])
                          * $signed({1'b0, n2_reg[j][LO_W-1:0]});
            px_lh_next[j] = $signed({1'b0, n1_reg[j][LO_W-1:0]})
                          * $signed(n2_reg[j][N_W-1:LO_W]);
            px_ll_next[j] = n1_reg[j][LO_W-1:0] * n2_reg[j][LO_W-1:0];
            ps_h_next[j]  = b1c_reg[j] * $signed(n2_reg[j][N_W-1:LO_W]);
            ps_l_next[j]  = b1c_reg[j] * $signed({1'b0, n2_reg[j][LO_W-1:0]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_hh_reg   <= px_hh_next;
            px_hl_reg   <= px_hl_next;
            px_lh_reg   <= px_lh_next;
            px_ll_reg   <= px_ll_next;
            ps_h_reg    <= ps_h_next;
            ps_l_reg    <= ps_l_next;
            len2_s3_reg <= len2_s2_reg;
        end
    end

    // ---------------- stage 4: x = n1 . n2, s = b1 . n2
    logic signed [X_W-1:0] x_next, x_s4_reg;
    logic signed [S_W-1:0] s_next, s_s4_reg;
    logic [LEN2_W-1:0]     len2_s4_reg;

    always_comb
    begin
        x_next = '0;
        s_next = '0;
        for (int j = 0; j < 3; j++)
        begin
            x_next = x_next + (X_W'(px_hh_reg[j]) <<< (2 * LO_W))
                   + ((X_W'(px_hl_reg[j]) + X_W'(px_lh_reg[j])) <<< LO_W)
                   + X_W'(px_ll_reg[j]);
            s_next = s_next + (S_W'(ps_h_reg[j]) <<< LO_W) + S_W'(ps_l_reg[j]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_s4_reg    <= x_next;
            s_s4_reg    <= s_next;
            len2_s4_reg <= len2_s3_reg;
        end
    end

    // ---------------- square root of |b2|^2 * 2^20, one result bit per stage
    logic [R_W-1:0]        sq_n_reg [SQRT_STAGES];
    logic [R_W-1:0]        sq_r_reg [SQRT_STAGES];
    logic signed [X_W-1:0] sq_x_reg [SQRT_STAGES];
    logic signed [S_W-1:0] sq_s_reg [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_sqrt
        localparam int E = 2 * (SQRT_STAGES - 1 - k);
        logic [R_W-1:0]        n_in, r_in, n_next, r_next, trial;
        logic signed [X_W-1:0] x_in;
        logic signed [S_W-1:0] s_in;

        if (k == 0)
        begin : g_first
            assign n_in = R_W'({len2_s4_reg, 20'b0});
            assign r_in = '0;
            assign x_in = x_s4_reg;
            assign s_in = s_s4_reg;
        end
        else
        begin : g_rest
            assign n_in = sq_n_reg[k-1];
            assign r_in = sq_r_reg[k-1];
            assign x_in = sq_x_reg[k-1];
            assign s_in = sq_s_reg[k-1];
        end

        always_comb
        begin
            trial = r_in + (R_W'(1) << E);
            if (n_in >= trial)
            begin
                n_next = n_in - trial;
                r_next = (r_in >> 1) + (R_W'(1) << E);
            end
            else
            begin
                n_next = n_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_n_reg[k] <= n_next;
                sq_r_reg[k] <= r_next;
                sq_x_reg[k] <= x_in;
                sq_s_reg[k] <= s_in;
            end
        end
    end

    // ---------------- M1: partial products of s * |b2|
    localparam int SH_W = S_W - 2 * LO_W;
    logic signed [LENF_W:0]          lenf_s;
    logic signed [SH_W+LENF_W:0]     ph_next, ph_reg;
    logic signed [LO_W+LENF_W+1:0]   pm_next, pm_reg, pl_next, pl_reg;
    logic signed [X_W-1:0]           x_m1_reg;

    always_comb
    begin
        lenf_s  = $signed({1'b0, sq_r_reg[SQRT_STAGES-1][LENF_W-1:0]});
        ph_next = $signed(sq_s_reg[SQRT_STAGES-1][S_W-1:2*LO_W]) * lenf_s;
        pm_next = $signed({1'b0, sq_s_reg[SQRT_STAGES-1][2*LO_W-1:LO_W]}) * lenf_s;
        pl_next = $signed({1'b0, sq_s_reg[SQRT_STAGES-1][LO_W-1:0]}) * lenf_s;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph_reg   <= ph_next;
            pm_reg   <= pm_next;
            pl_reg   <= pl_next;
            x_m1_reg <= sq_x_reg[SQRT_STAGES-1];
        end
    end

    // ---------------- M2: y = -(s * |b2|)
    logic signed [Y_W-1:0] y_next, y_m2_reg;
    logic signed [X_W-1:0] x_m2_reg;

    assign y_next = -((Y_W'(ph_reg) <<< (2 * LO_W)) + (Y_W'(pm_reg) <<< LO_W) + Y_W'(pl_reg));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_m2_reg <= y_next;
            x_m2_reg <= x_m1_reg;
        end
    end

    // ---------------- M3: signs and magnitudes, x scaled by 2^10
    logic [X_W-1:0] ax;
    logic [Y_W-1:0] ay;
    logic [U_W-1:0] ux_next, uy_next, ux_m3_reg, uy_m3_reg;
    logic           xneg_m3_reg, yneg_m3_reg;

    always_comb
    begin
        ax      = x_m2_reg[X_W-1] ? $unsigned(-x_m2_reg) : $unsigned(x_m2_reg);
        ay      = y_m2_reg[Y_W-1] ? $unsigned(-y_m2_reg) : $unsigned(y_m2_reg);
        ux_next = {{(U_W-X_W-10){1'b0}}, ax, 10'b0};
        uy_next = {{(U_W-Y_W){1'b0}}, ay};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ux_m3_reg   <= ux_next;
            uy_m3_reg   <= uy_next;
            xneg_m3_reg <= x_m2_reg[X_W-1];
            yneg_m3_reg <= y_m2_reg[Y_W-1];
        end
    end

    // ---------------- normalize: shift both left until the larger has its MSB on top
    logic [U_W-1:0] nm_x_reg [NORM_STAGES];
    logic [U_W-1:0] nm_y_reg [NORM_STAGES];
    logic           nm_xneg_reg [NORM_STAGES];
    logic           nm_yneg_reg [NORM_STAGES];

    for (genvar k = 0; k < NORM_STAGES; k++)
    begin : g_norm
        localparam int SH = (U_W / 2) >> k;
        logic [U_W-1:0] x_in, y_in, orv, x_next, y_next;
        logic           xn_in, yn_in;

        if (k == 0)
        begin : g_first
            assign x_in  = ux_m3_reg;
            assign y_in  = uy_m3_reg;
            assign xn_in = xneg_m3_reg;
            assign yn_in = yneg_m3_reg;
        end
        else
        begin : g_rest
            assign x_in  = nm_x_reg[k-1];
            assign y_in  = nm_y_reg[k-1];
            assign xn_in = nm_xneg_reg[k-1];
            assign yn_in = nm_yneg_reg[k-1];
        end

        always_comb
        begin
            orv = x_in | y_in;
            if (orv[U_W-1 -: SH] == '0)
            begin
                x_next = x_in << SH;
                y_next = y_in << SH;
            end
            else
            begin
                x_next = x_in;
                y_next = y_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nm_x_reg[k]    <= x_next;
                nm_y_reg[k]    <= y_next;
                nm_xneg_reg[k] <= xn_in;
                nm_yneg_reg[k] <= yn_in;
            end
        end
    end

    // ---------------- vectoring CORDIC, one rotation per stage
    logic signed [CX_W-1:0] cr_x_reg [CORDIC_STAGES];
    logic signed [CX_W-1:0] cr_y_reg [CORDIC_STAGES];
    logic signed [Z_W-1:0]  cr_z_reg [CORDIC_STAGES];
    logic                   cr_xneg_reg [CORDIC_STAGES];
    logic                   cr_yneg_reg [CORDIC_STAGES];

    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_cordic
        localparam logic [Z_W-1:0] ATAN = Z_W'(atan_q16(k));
        logic signed [CX_W-1:0] x_in, y_in, x_next, y_next;
        logic signed [Z_W-1:0]  z_in, z_next;
        logic                   xn_in, yn_in;

        if (k == 0)
        begin : g_first
            assign x_in  = $signed(CX_W'(nm_x_reg[NORM_STAGES-1][U_W-1 -: CV_W]));
            assign y_in  = $signed(CX_W'(nm_y_reg[NORM_STAGES-1][U_W-1 -: CV_W]));
            assign z_in  = '0;
            assign xn_in = nm_xneg_reg[NORM_STAGES-1];
            assign yn_in = nm_yneg_reg[NORM_STAGES-1];
        end
        else
        begin : g_rest
            assign x_in  = cr_x_reg[k-1];
            assign y_in  = cr_y_reg[k-1];
            assign z_in  = cr_z_reg[k-1];
            assign xn_in = cr_xneg_reg[k-1];
            assign yn_in = cr_yneg_reg[k-1];
        end

        always_comb
        begin
            if (y_in > 0)
            begin
                x_next = x_in + (y_in >>> k);
                y_next = y_in - (x_in >>> k);
                z_next = z_in + $signed(ATAN);
            end
            else
            begin
                x_next = x_in - (y_in >>> k);
                y_next = y_in + (x_in >>> k);
                z_next = z_in - $signed(ATAN);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cr_x_reg[k]    <= x_next;
                cr_y_reg[k]    <= y_next;
                cr_z_reg[k]    <= z_next;
                cr_xneg_reg[k] <= xn_in;
                cr_yneg_reg[k] <= yn_in;
            end
        end
    end

    // ---------------- P1: clamp to 0..90 degrees, fold into the quadrant
    logic signed [Z_W-1:0] zf;
    logic [MAG_W-1:0]      zc, mag_next, mag_reg;
    logic                  xneg_p1_reg, yneg_p1_reg;

    always_comb
    begin
        zf = cr_z_reg[CORDIC_STAGES-1];
        if (zf < 0)
        begin
            zc = '0;
        end
        else if (zf > $signed(Z_W'(DEG90_Q16)))
        begin
            zc = DEG90_Q16;
        end
        else
        begin
            zc = MAG_W'(zf);
        end
        mag_next = cr_xneg_reg[CORDIC_STAGES-1] ? DEG180_Q16 - zc : zc;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg     <= mag_next;
            xneg_p1_reg <= cr_xneg_reg[CORDIC_STAGES-1];
            yneg_p1_reg <= cr_yneg_reg[CORDIC_STAGES-1];
        end
    end

    // ---------------- P2: hundredths of a degree, round half up, apply sign
    logic [30:0]      scaled;
    logic [CD_W-2:0]  cd_mag;
    dau_out_t         out_next, out_reg;

    always_comb
    begin
        scaled = 31'(mag_reg) * 31'(100) + 31'(32768);
        cd_mag = scaled[30:16];
        out_next.torsion_angle = yneg_p1_reg ? -$signed({1'b0, cd_mag})
                                             : $signed({1'b0, cd_mag});
        out_next.within_ninety = !xneg_p1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

    // ---------------- assertions
    a_flag_matches_angle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.within_ninety
            ? (out_data.torsion_angle >= -CD_90 && out_data.torsion_angle <= CD_90)
            : (out_data.torsion_angle >= CD_90 || out_data.torsion_angle <= -CD_90)))
        else $error("within_ninety disagrees with torsion_angle");

    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.torsion_angle >= -CD_180 && out_data.torsion_angle <= CD_180))
        else $error("torsion_angle out of range");

    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(valid_reg))
        else $error("pipeline moved during a stall");

    a_norm_top_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[NORM_LAST] && ((nm_x_reg[NORM_STAGES-1] | nm_y_reg[NORM_STAGES-1]) != '0))
        |-> (nm_x_reg[NORM_STAGES-1][U_W-1] || nm_y_reg[NORM_STAGES-1][U_W-1]))
        else $error("normalizer left the leading one below the top bit");

endmodule

`default_nettype wire
